// File: rtl/ufrc_pkg.sv
// ----------------------------------------------------------------------------
// ufrc_pkg: shared types, constants and functions of the UART frame receiver
// Holds the channel structs, the job record passed from front to back, the
// character codes of the protocol and the CRC16-CCITT-FALSE byte update.
// ----------------------------------------------------------------------------
package ufrc_pkg;

   // payload buffer and result limits
   localparam int MAX_PAYLOAD  = 63;
   localparam int MAX_RESULTS  = 64;
   localparam int BUF_AW       = $clog2(MAX_PAYLOAD);
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   // input command codes
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // result kinds
   localparam logic [1:0] KIND_TX    = 2'd0;
   localparam logic [1:0] KIND_ADC   = 2'd1;
   localparam logic [1:0] KIND_FRAME = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_TIMEOUT = 2'd0;
   localparam logic [1:0] CSR_VERSION = 2'd1;
   localparam logic [1:0] CSR_MAX_LEN = 2'd2;

   // register reset values
   localparam logic [9:0] TIMEOUT_RST = 10'd200;
   localparam logic [7:0] VERSION_RST = 8'd1;
   localparam logic [5:0] MAX_LEN_RST = 6'd63;

   // crc
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   // nack and error codes
   localparam logic [7:0] NACK_BYTE   = 8'h15;
   localparam logic [7:0] ERR_VERSION = 8'd1;
   localparam logic [7:0] ERR_LENGTH  = 8'd2;
   localparam logic [7:0] ERR_CRC     = 8'd3;

   // characters of the start word and the one-byte requests
   localparam logic [7:0] CH_B_UP   = 8'h42;
   localparam logic [7:0] CH_L_UP   = 8'h4C;
   localparam logic [7:0] CH_U_UP   = 8'h55;
   localparam logic [7:0] CH_P_UP   = 8'h50;
   localparam logic [7:0] CH_QUERY  = 8'h3F;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_D_UP   = 8'h44;
   localparam logic [7:0] CH_D_LO   = 8'h64;
   localparam logic [7:0] CH_A_UP   = 8'h41;

   // debug progress letters
   localparam logic [7:0] CH_S_UP   = 8'h53;
   localparam logic [7:0] CH_H_UP   = 8'h48;
   localparam logic [7:0] CH_H_LO   = 8'h68;
   localparam logic [7:0] CH_V_LO   = 8'h76;
   localparam logic [7:0] CH_L_LO   = 8'h6C;
   localparam logic [7:0] CH_P_LO   = 8'h70;
   localparam logic [7:0] CH_T_UP   = 8'h54;
   localparam logic [7:0] CH_T_LO   = 8'h74;
   localparam logic [7:0] CH_C_UP   = 8'h43;
   localparam logic [7:0] CH_C_LO   = 8'h63;

   // input item
   typedef struct packed {
      logic       command;
      logic [7:0] rx_byte;
   } req_type;

   // result item
   typedef struct packed {
      logic [1:0]  out_kind;
      logic [7:0]  tx_byte;
      logic [7:0]  frame_command;
      logic [15:0] frame_seq;
      logic [5:0]  frame_length;
      logic [7:0]  payload_byte;
      logic        last;
   } rsp_type;

   // up to four transmit bytes in send order
   typedef struct packed {
      logic [2:0]      count;
      logic [3:0][7:0] bytes;
   } tx_list_type;

   // work record for one input item
   typedef struct packed {
      tx_list_type tx;
      logic        adc;
      logic        replay;
      logic [7:0]  cmd;
      logic [15:0] seq;
      logic [5:0]  len;
      logic [5:0]  last_idx;
   } job_type;

   // payload buffer write from front to back
   typedef struct packed {
      logic              en;
      logic [BUF_AW-1:0] addr;
      logic [7:0]        data;
   } buf_wr_type;

   // back status toward front
   typedef struct packed {
      logic replay_done;
   } back_status_type;

   // one byte of crc16-ccitt-false, msb first
   function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

   // append one byte to a transmit list
   function automatic tx_list_type tx_push(tx_list_type l, logic [7:0] b);
      tx_list_type r;
      r = l;
      r.bytes[l.count[1:0]] = b;
      r.count = l.count + 3'd1;
      return r;
   endfunction

   // append a debug letter only while debug echo is on
   function automatic tx_list_type tx_dbg(tx_list_type l, logic on, logic [7:0] b);
      tx_list_type r;
      r = on ? tx_push(l, b) : l;
      return r;
   endfunction

endpackage

// File: rtl/ufrc_front.sv
// ----------------------------------------------------------------------------
// ufrc_front: frame parser
// Accepts bytes and ticks, runs the hunt / header / payload / crc sequence,
// writes payload bytes to the buffer and pushes one job per item that
// produces results.
// ----------------------------------------------------------------------------
module ufrc_front import ufrc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_type         req_data,
   input  logic            csr_wr_en,
   input  logic [1:0]      csr_index,
   input  logic [9:0]      csr_wdata,
   output logic            job_valid,
   output job_type         job_data,
   input  logic            q_full,
   output buf_wr_type      buf_wr,
   input  back_status_type back_status
);

   // phase codes
   localparam logic [1:0] PH_HUNT    = 2'd0;
   localparam logic [1:0] PH_HEADER  = 2'd1;
   localparam logic [1:0] PH_PAYLOAD = 2'd2;
   localparam logic [1:0] PH_CRC     = 2'd3;

   localparam logic [3:0][7:0] SOF_WORD = {CH_P_UP, CH_U_UP, CH_L_UP, CH_B_UP};

   logic [9:0]      cfg_timeout_ff;
   logic [7:0]      cfg_version_ff;
   logic [5:0]      cfg_max_ff;

   logic [1:0]      phase_ff, phase_in;
   logic [1:0]      sof_ff, sof_in;
   logic [5:0]      bcnt_ff, bcnt_in;
   logic [9:0]      tcnt_ff, tcnt_in;
   logic [5:0][7:0] hdr_ff, hdr_in;
   logic [15:0]     crc_ff, crc_in;
   logic [7:0]      crc_hi_ff, crc_hi_in;
   logic            dbg_ff, dbg_in;
   logic [1:0]      pend_ff, pend_in;

   logic            accept;
   logic [9:0]      tick_sat;
   logic [5:0]      bcnt_inc;
   logic [15:0]     len16;
   logic [15:0]     rx_crc;
   logic [15:0]     crc_nx;
   logic [7:0]      rx_b;
   tx_list_type     tl;
   job_type         job;
   logic            fail;
   logic [7:0]      fail_letter;
   logic [7:0]      fail_code;
   logic            pend_up;

   // stall on a full queue, or in payload while a replay reads the buffer
   assign req_ready = !q_full && !(phase_ff == PH_PAYLOAD && pend_ff != 2'd0);
   assign accept    = req_valid && req_ready;
   assign rx_b      = req_data.rx_byte;

   // parser next state
   always_comb begin
      tl          = '0;
      job         = '0;
      fail        = 1'b0;
      fail_letter = 8'h00;
      fail_code   = 8'h00;
      phase_in    = phase_ff;
      sof_in      = sof_ff;
      bcnt_in     = bcnt_ff;
      tcnt_in     = tcnt_ff;
      hdr_in      = hdr_ff;
      crc_in      = crc_ff;
      crc_hi_in   = crc_hi_ff;
      dbg_in      = dbg_ff;
      buf_wr      = '0;
      tick_sat    = (tcnt_ff == 10'h3FF) ? tcnt_ff : tcnt_ff + 10'd1;
      bcnt_inc    = bcnt_ff + 6'd1;
      len16       = {hdr_ff[4], rx_b};
      rx_crc      = {crc_hi_ff, rx_b};
      crc_nx      = crc_step(crc_ff, rx_b);
      if (accept) begin
         if (req_data.command == CMD_TICK) begin
            // segment timeout
            if (phase_ff != PH_HUNT) begin
               tcnt_in = tick_sat;
               if (tick_sat >= cfg_timeout_ff) begin
                  fail      = 1'b1;
                  fail_code = ERR_LENGTH;
                  case (phase_ff)
                     PH_HEADER:  fail_letter = CH_H_LO;
                     PH_PAYLOAD: fail_letter = CH_P_LO;
                     default:    fail_letter = CH_T_LO;
                  endcase
               end
            end
         end else begin
            case (phase_ff)
               PH_HUNT: begin
                  if (rx_b == CH_QUERY) begin
                     tl = tx_push(tl, CH_BANG);
                  end else if (rx_b == CH_D_UP) begin
                     dbg_in = 1'b1;
                     tl     = tx_push(tl, CH_D_LO);
                  end else if (rx_b == CH_A_UP) begin
                     job.adc = 1'b1;
                  end else if (rx_b == SOF_WORD[sof_ff]) begin
                     if (sof_ff == 2'd3) begin
                        tl        = tx_dbg(tl, dbg_ff, CH_S_UP);
                        crc_in    = CRC_INIT;
                        crc_hi_in = 8'h00;
                        phase_in  = PH_HEADER;
                        bcnt_in   = 6'd0;
                        tcnt_in   = 10'd0;
                        sof_in    = 2'd0;
                     end else begin
                        sof_in = sof_ff + 2'd1;
                     end
                  end else begin
                     sof_in = (rx_b == CH_B_UP) ? 2'd1 : 2'd0;
                  end
               end
               PH_HEADER: begin
                  hdr_in[bcnt_ff[2:0]] = rx_b;
                  crc_in  = crc_nx;
                  bcnt_in = bcnt_inc;
                  if (bcnt_inc >= 6'd6) begin
                     tl = tx_dbg(tl, dbg_ff, CH_H_UP);
                     if (hdr_ff[0] != cfg_version_ff) begin
                        fail        = 1'b1;
                        fail_letter = CH_V_LO;
                        fail_code   = ERR_VERSION;
                     end else if (len16 > {10'd0, cfg_max_ff} ||
                                  len16 > 16'(MAX_PAYLOAD)) begin
                        fail        = 1'b1;
                        fail_letter = CH_L_LO;
                        fail_code   = ERR_LENGTH;
                     end else if (len16 == 16'd0) begin
                        tl       = tx_dbg(tl, dbg_ff, CH_P_UP);
                        phase_in = PH_CRC;
                        bcnt_in  = 6'd0;
                        tcnt_in  = 10'd0;
                     end else begin
                        phase_in = PH_PAYLOAD;
                        bcnt_in  = 6'd0;
                        tcnt_in  = 10'd0;
                     end
                  end
               end
               PH_PAYLOAD: begin
                  buf_wr.en   = 1'b1;
                  buf_wr.addr = bcnt_ff[BUF_AW-1:0];
                  buf_wr.data = rx_b;
                  crc_in      = crc_nx;
                  bcnt_in     = bcnt_inc;
                  if (bcnt_inc >= hdr_ff[5][5:0]) begin
                     tl       = tx_dbg(tl, dbg_ff, CH_P_UP);
                     phase_in = PH_CRC;
                     bcnt_in  = 6'd0;
                     tcnt_in  = 10'd0;
                  end
               end
               default: begin
                  if (bcnt_ff == 6'd0) begin
                     crc_hi_in = rx_b;
                     bcnt_in   = 6'd1;
                  end else begin
                     tl = tx_dbg(tl, dbg_ff, CH_T_UP);
                     if (rx_crc != crc_ff) begin
                        fail        = 1'b1;
                        fail_letter = CH_C_LO;
                        fail_code   = ERR_CRC;
                     end else begin
                        // accepted frame: replay from the buffer
                        tl         = tx_dbg(tl, dbg_ff, CH_C_UP);
                        job.replay = 1'b1;
                        job.cmd    = hdr_ff[1];
                        job.seq    = {hdr_ff[2], hdr_ff[3]};
                        job.len    = hdr_ff[5][5:0];
                        dbg_in     = 1'b0;
                        phase_in   = PH_HUNT;
                        sof_in     = 2'd0;
                        bcnt_in    = 6'd0;
                        tcnt_in    = 10'd0;
                     end
                  end
               end
            endcase
         end
         // rejected frame: letter, nack, code, back to hunting
         if (fail) begin
            tl       = tx_dbg(tl, dbg_ff, fail_letter);
            tl       = tx_push(tl, NACK_BYTE);
            tl       = tx_push(tl, fail_code);
            phase_in = PH_HUNT;
            sof_in   = 2'd0;
            bcnt_in  = 6'd0;
            tcnt_in  = 10'd0;
         end
      end
      job.tx = tl;
      // index of the final frame item, limited by the result cap
      if (job.len == 6'd0) begin
         job.last_idx = 6'd0;
      end else if (({1'b0, job.len} + {4'd0, tl.count}) > 7'(MAX_RESULTS)) begin
         job.last_idx = 6'(7'(MAX_RESULTS - 1) - {4'd0, tl.count});
      end else begin
         job.last_idx = job.len - 6'd1;
      end
   end

   assign job_data  = job;
   assign job_valid = accept && (tl.count != 3'd0 || job.adc || job.replay);

   // replays that still read the buffer
   assign pend_up = job_valid && job.replay && job.len != 6'd0;
   always_comb begin
      pend_in = pend_ff;
      if (pend_up && !back_status.replay_done) begin
         pend_in = pend_ff + 2'd1;
      end else if (!pend_up && back_status.replay_done) begin
         pend_in = pend_ff - 2'd1;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         sof_ff    <= 2'd0;
         bcnt_ff   <= 6'd0;
         tcnt_ff   <= 10'd0;
         crc_ff    <= CRC_INIT;
         crc_hi_ff <= 8'h00;
         dbg_ff    <= 1'b0;
         pend_ff   <= 2'd0;
      end else begin
         phase_ff  <= phase_in;
         sof_ff    <= sof_in;
         bcnt_ff   <= bcnt_in;
         tcnt_ff   <= tcnt_in;
         crc_ff    <= crc_in;
         crc_hi_ff <= crc_hi_in;
         dbg_ff    <= dbg_in;
         pend_ff   <= pend_in;
      end
   end

   // header bytes
   always_ff @(posedge clock) begin
      hdr_ff <= hdr_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_timeout_ff <= TIMEOUT_RST;
         cfg_version_ff <= VERSION_RST;
         cfg_max_ff     <= MAX_LEN_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_TIMEOUT: cfg_timeout_ff <= csr_wdata;
            CSR_VERSION: cfg_version_ff <= csr_wdata[7:0];
            CSR_MAX_LEN: cfg_max_ff     <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

endmodule

// File: rtl/ufrc_queue.sv
// ----------------------------------------------------------------------------
// ufrc_queue: job queue between parser and result sequencer
// Small first-in first-out buffer of job records.
// ----------------------------------------------------------------------------
module ufrc_queue import ufrc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    full,
   input  logic    pop,
   output job_type pop_data,
   output logic    not_empty
);

   job_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] cnt_ff;
   logic              do_push;
   logic              do_pop;

   assign full      = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + QCNT_W'(1);
         end else if (!do_push && do_pop) begin
            cnt_ff <= cnt_ff - QCNT_W'(1);
         end
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/ufrc_back.sv
// ----------------------------------------------------------------------------
// ufrc_back: result sequencer
// Pops jobs and sends their results one at a time through an output
// register; owns the payload buffer and replays accepted frames from it.
// ----------------------------------------------------------------------------
module ufrc_back import ufrc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_not_empty,
   output logic            q_pop,
   input  job_type         q_data,
   input  buf_wr_type      buf_wr,
   output back_status_type status,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_type         rsp_data
);

   // sequencer states
   localparam logic [2:0] B_IDLE  = 3'd0;
   localparam logic [2:0] B_TX    = 3'd1;
   localparam logic [2:0] B_ADC   = 3'd2;
   localparam logic [2:0] B_FETCH = 3'd3;
   localparam logic [2:0] B_ITEM  = 3'd4;

   logic [7:0]        buf_mem [MAX_PAYLOAD];
   logic [7:0]        rd_data_ff;

   logic [2:0]        st_ff, st_in;
   job_type           cur_ff, cur_in;
   logic [1:0]        tx_idx_ff, tx_idx_in;
   logic [BUF_AW-1:0] item_idx_ff, item_idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff;

   logic              out_free;
   logic              emit;
   rsp_type           emit_data;
   logic              tx_last;
   logic              item_last;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // sequencer next state
   always_comb begin
      st_in              = st_ff;
      cur_in             = cur_ff;
      tx_idx_in          = tx_idx_ff;
      item_idx_in        = item_idx_ff;
      q_pop              = 1'b0;
      emit               = 1'b0;
      emit_data          = '0;
      status.replay_done = 1'b0;
      tx_last            = ({1'b0, tx_idx_ff} + 3'd1) == cur_ff.tx.count;
      item_last          = (item_idx_ff == cur_ff.last_idx);
      case (st_ff)
         B_IDLE: begin
            if (q_not_empty) begin
               q_pop       = 1'b1;
               cur_in      = q_data;
               tx_idx_in   = 2'd0;
               item_idx_in = '0;
               if (q_data.tx.count != 3'd0) begin
                  st_in = B_TX;
               end else if (q_data.adc) begin
                  st_in = B_ADC;
               end else begin
                  st_in = B_FETCH;
               end
            end
         end
         B_TX: begin
            if (out_free) begin
               emit              = 1'b1;
               emit_data.out_kind = KIND_TX;
               emit_data.tx_byte = cur_ff.tx.bytes[tx_idx_ff];
               emit_data.last    = tx_last && !cur_ff.replay;
               tx_idx_in         = tx_idx_ff + 2'd1;
               if (tx_last) begin
                  st_in = cur_ff.replay ? B_FETCH : B_IDLE;
               end
            end
         end
         B_ADC: begin
            if (out_free) begin
               emit               = 1'b1;
               emit_data.out_kind = KIND_ADC;
               emit_data.last     = 1'b1;
               st_in              = B_IDLE;
            end
         end
         B_FETCH: begin
            // buffer read lands in rd_data_ff
            st_in = B_ITEM;
         end
         B_ITEM: begin
            if (out_free) begin
               emit                    = 1'b1;
               emit_data.out_kind      = KIND_FRAME;
               emit_data.frame_command = cur_ff.cmd;
               emit_data.frame_seq     = cur_ff.seq;
               emit_data.frame_length  = cur_ff.len;
               emit_data.payload_byte  = (cur_ff.len == 6'd0) ? 8'h00 : rd_data_ff;
               emit_data.last          = item_last;
               item_idx_in             = item_idx_ff + BUF_AW'(1);
               if (item_last) begin
                  st_in              = B_IDLE;
                  status.replay_done = (cur_ff.len != 6'd0);
               end else begin
                  st_in = B_FETCH;
               end
            end
         end
         default: st_in = B_IDLE;
      endcase
      rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= B_IDLE;
         tx_idx_ff    <= 2'd0;
         item_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         tx_idx_ff    <= tx_idx_in;
         item_idx_ff  <= item_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // current job and output register
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (emit) begin
         rsp_ff <= emit_data;
      end
   end

   // payload buffer
   always_ff @(posedge clock) begin
      if (buf_wr.en) begin
         buf_mem[buf_wr.addr] <= buf_wr.data;
      end
      rd_data_ff <= buf_mem[item_idx_ff];
   end

endmodule

// File: rtl/uart_frame_receiver_crc16_top.sv
// ----------------------------------------------------------------------------
// uart_frame_receiver_crc16_top: UART frame receiver with CRC16 check
//
//   channel  ports                              direction
//   req      req_valid / req_ready / req_data   in: received byte or tick
//   rsp      rsp_valid / rsp_ready / rsp_data   out: tx byte, adc, frame item
//   csr      csr_wr_en / csr_index / csr_wdata  in: register write
//
// The parser takes one item per cycle and pushes a job into a two-entry queue.
// The sequencer pops each job in its idle state, then sends transmit and
// adc results at one per cycle while the receiver is ready, through the
// output register. Each frame item is a payload buffer read, then the
// output register, and the next byte is read only after the last is sent.
// The input stalls while the queue is full, and payload bytes of a new frame
// stall until the previous replay is done with the buffer. Reset is
// synchronous and clears the parser, the queue and the sequencer; the buffer
// needs no clearing.
// ----------------------------------------------------------------------------
module uart_frame_receiver_crc16_top import ufrc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [9:0] csr_wdata
);

   logic            job_valid;
   job_type         job_data;
   logic            q_full;
   logic            q_pop;
   job_type         q_data;
   logic            q_not_empty;
   buf_wr_type      buf_wr;
   back_status_type back_status;

   // parser
   ufrc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .job_valid   (job_valid),
      .job_data    (job_data),
      .q_full      (q_full),
      .buf_wr      (buf_wr),
      .back_status (back_status)
   );

   // job queue
   ufrc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_valid),
      .push_data (job_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .not_empty (q_not_empty)
   );

   // result sequencer
   ufrc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_pop       (q_pop),
      .q_data      (q_data),
      .buf_wr      (buf_wr),
      .status      (back_status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   // an adc request is always the only result of its item
   a_adc_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_kind == KIND_ADC |-> rsp_data.last)
      else $error("adc result without last");

   // no transfer accepted while the queue is full
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !req_ready)
      else $error("input accepted with full queue");

   // jobs are only pushed on an accepted transfer
   a_push_on_accept: assert property (@(posedge clock) disable iff (reset)
      job_valid |-> req_valid && req_ready)
      else $error("job pushed without input transfer");

   // payload buffer is only written on an accepted transfer
   a_buf_wr_accept: assert property (@(posedge clock) disable iff (reset)
      buf_wr.en |-> req_valid && req_ready)
      else $error("buffer write without input transfer");

endmodule

// File: dv/ufrc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ufrc_checker: result predictor and scoreboard for the uart frame receiver
// Watches the request, response and register ports of the block. Every
// accepted request is run through a cycle-free model of the deframer. The
// model covers the hunting requests, start word matching, the header,
// payload and crc segments with tick timeouts, debug letters and payload
// replay. The results it predicts are queued. Each response transfer is
// compared field by field against the oldest queued result.
// ----------------------------------------------------------------------------
module ufrc_checker import ufrc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  req_type    req_data,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  rsp_type    rsp_data,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [9:0] csr_wdata,
   output int         error_count,
   output int         pending_count,
   output int         checked_count,
   output int         frame_count
);

   typedef enum logic [1:0] {SEG_HUNT, SEG_HEADER, SEG_PAYLOAD, SEG_CRC} seg_type;

   // register copies
   logic [9:0] cfg_timeout;
   logic [7:0] cfg_version;
   logic [5:0] cfg_max_len;

   // deframer state
   seg_type     seg_phase;
   logic [1:0]  sof_idx;
   int          seg_bytes;
   logic [9:0]  seg_ticks;
   logic [7:0]  hdr_q [6];
   logic [15:0] crc_acc;
   logic [7:0]  crc_hi;
   logic [7:0]  pbuf [MAX_PAYLOAD];
   logic        dbg_on;

   // results of the current request and all results still owed
   rsp_type step_rsp[$];
   rsp_type expected_rsp[$];

   int err_n = 0;
   int chk_n = 0;
   int frm_n = 0;

   // crc16-ccitt-false, one input bit at a time
   function automatic logic [15:0] crc16_next(logic [15:0] c, logic [7:0] d);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ d[i];
         c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return c;
   endfunction

   function automatic logic [7:0] sof_char(logic [1:0] idx);
      case (idx)
         2'd0:    return CH_B_UP;
         2'd1:    return CH_L_UP;
         2'd2:    return CH_U_UP;
         default: return CH_P_UP;
      endcase
   endfunction

   function automatic logic [15:0] hdr_len();
      return {hdr_q[4], hdr_q[5]};
   endfunction

   task automatic report_mismatch(string what);
      err_n++;
      if (err_n <= 40) $display("ufrc_checker: %0t result %0d: %s", $time, chk_n, what);
   endtask

   // append one result, dropping anything past the per-request cap
   task automatic push_result(logic [1:0] kind, logic [7:0] tx, logic [7:0] cmd,
                              logic [15:0] seq, logic [5:0] len, logic [7:0] pl);
      rsp_type r;
      if (step_rsp.size() >= MAX_RESULTS) return;
      r.out_kind      = kind;
      r.tx_byte       = tx;
      r.frame_command = cmd;
      r.frame_seq     = seq;
      r.frame_length  = len;
      r.payload_byte  = pl;
      r.last          = 1'b0;
      step_rsp.push_back(r);
   endtask

   task automatic send_tx(logic [7:0] b);
      push_result(KIND_TX, b, 8'h00, 16'h0000, 6'd0, 8'h00);
   endtask

   task automatic debug_letter(logic [7:0] c);
      if (dbg_on) send_tx(c);
   endtask

   task automatic go_hunt();
      seg_phase = SEG_HUNT;
      sof_idx   = 2'd0;
      seg_bytes = 0;
      seg_ticks = 10'd0;
   endtask

   task automatic start_seg(seg_type ph);
      seg_phase = ph;
      seg_bytes = 0;
      seg_ticks = 10'd0;
   endtask

   // letter, nack, code, back to hunting
   task automatic reject(logic [7:0] letter, logic [7:0] code);
      debug_letter(letter);
      send_tx(NACK_BYTE);
      send_tx(code);
      go_hunt();
   endtask

   task automatic header_done();
      logic [15:0] len;
      len = hdr_len();
      debug_letter(CH_H_UP);
      if (hdr_q[0] != cfg_version) begin
         reject(CH_V_LO, ERR_VERSION);
      end else if (len > cfg_max_len || len > MAX_PAYLOAD) begin
         reject(CH_L_LO, ERR_LENGTH);
      end else if (len == 16'd0) begin
         debug_letter(CH_P_UP);
         start_seg(SEG_CRC);
      end else begin
         start_seg(SEG_PAYLOAD);
      end
   endtask

   task automatic crc_done(logic [7:0] low);
      logic [15:0] len;
      logic [15:0] seq;
      debug_letter(CH_T_UP);
      if ({crc_hi, low} != crc_acc) begin
         reject(CH_C_LO, ERR_CRC);
         return;
      end
      debug_letter(CH_C_UP);
      len = hdr_len();
      seq = {hdr_q[2], hdr_q[3]};
      if (len == 16'd0) begin
         push_result(KIND_FRAME, 8'h00, hdr_q[1], seq, 6'd0, 8'h00);
      end else begin
         for (int i = 0; i < len; i++) push_result(KIND_FRAME, 8'h00, hdr_q[1], seq,
                                                   len[5:0], pbuf[i]);
      end
      dbg_on = 1'b0;
      frm_n++;
      go_hunt();
   endtask

   // one-byte requests and start word matching
   task automatic hunt_byte(logic [7:0] b);
      if (b == CH_QUERY) begin
         send_tx(CH_BANG);
      end else if (b == CH_D_UP) begin
         dbg_on = 1'b1;
         send_tx(CH_D_LO);
      end else if (b == CH_A_UP) begin
         push_result(KIND_ADC, 8'h00, 8'h00, 16'h0000, 6'd0, 8'h00);
      end else if (b == sof_char(sof_idx)) begin
         if (sof_idx == 2'd3) begin
            debug_letter(CH_S_UP);
            crc_acc = CRC_INIT;
            crc_hi  = 8'h00;
            start_seg(SEG_HEADER);
            sof_idx = 2'd0;
         end else begin
            sof_idx++;
         end
      end else begin
         sof_idx = (b == CH_B_UP) ? 2'd1 : 2'd0;
      end
   endtask

   task automatic segment_byte(logic [7:0] b);
      case (seg_phase)
         SEG_HEADER: begin
            hdr_q[seg_bytes % 6] = b;
            crc_acc = crc16_next(crc_acc, b);
            seg_bytes++;
            if (seg_bytes >= 6) header_done();
         end
         SEG_PAYLOAD: begin
            if (seg_bytes < MAX_PAYLOAD) pbuf[seg_bytes] = b;
            crc_acc = crc16_next(crc_acc, b);
            seg_bytes++;
            if (seg_bytes >= hdr_len()) begin
               debug_letter(CH_P_UP);
               start_seg(SEG_CRC);
            end
         end
         default: begin
            if (seg_bytes == 0) begin
               crc_hi    = b;
               seg_bytes = 1;
            end else begin
               crc_done(b);
            end
         end
      endcase
   endtask

   // saturating tick count, timeout per segment
   task automatic segment_tick();
      if (seg_ticks != 10'h3FF) seg_ticks++;
      if (seg_ticks >= cfg_timeout) begin
         case (seg_phase)
            SEG_HEADER:  reject(CH_H_LO, ERR_LENGTH);
            SEG_PAYLOAD: reject(CH_P_LO, ERR_LENGTH);
            default:     reject(CH_T_LO, ERR_LENGTH);
         endcase
      end
   endtask

   task automatic predict_item(req_type item);
      rsp_type r;
      step_rsp.delete();
      if (item.command == CMD_TICK) begin
         if (seg_phase != SEG_HUNT) segment_tick();
      end else if (seg_phase == SEG_HUNT) begin
         hunt_byte(item.rx_byte);
      end else begin
         segment_byte(item.rx_byte);
      end
      if (step_rsp.size() > 0) begin
         r = step_rsp.pop_back();
         r.last = 1'b1;
         step_rsp.push_back(r);
      end
      foreach (step_rsp[i]) expected_rsp.push_back(step_rsp[i]);
   endtask

   task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
   endtask

   task automatic check_result(rsp_type got);
      rsp_type want;
      if (expected_rsp.size() == 0) begin
         report_mismatch($sformatf("unexpected result %h", got));
         return;
      end
      want = expected_rsp.pop_front();
      chk_n++;
      compare_field("out_kind", 16'(got.out_kind), 16'(want.out_kind));
      compare_field("tx_byte", 16'(got.tx_byte), 16'(want.tx_byte));
      compare_field("frame_command", 16'(got.frame_command), 16'(want.frame_command));
      compare_field("frame_seq", got.frame_seq, want.frame_seq);
      compare_field("frame_length", 16'(got.frame_length), 16'(want.frame_length));
      compare_field("payload_byte", 16'(got.payload_byte), 16'(want.payload_byte));
      compare_field("last", 16'(got.last), 16'(want.last));
   endtask

   task automatic restart_model();
      cfg_timeout = TIMEOUT_RST;
      cfg_version = VERSION_RST;
      cfg_max_len = MAX_LEN_RST;
      go_hunt();
      foreach (hdr_q[i]) hdr_q[i] = 8'h00;
      foreach (pbuf[i]) pbuf[i] = 8'h00;
      crc_acc = CRC_INIT;
      crc_hi  = 8'h00;
      dbg_on  = 1'b0;
      expected_rsp.delete();
   endtask

   // sample every port at the clock edge
   always @(posedge clock) begin
      if (reset) begin
         restart_model();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_TIMEOUT: cfg_timeout = csr_wdata;
               CSR_VERSION: cfg_version = csr_wdata[7:0];
               CSR_MAX_LEN: cfg_max_len = csr_wdata[5:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) predict_item(req_data);
         if (rsp_valid && rsp_ready) check_result(rsp_data);
      end
      error_count   <= err_n;
      pending_count <= expected_rsp.size();
      checked_count <= chk_n;
      frame_count   <= frm_n;
   end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the uart frame receiver
// Drives received bytes and ticks into the block: well-formed frames with
// random content, frames with a bad version, length or crc, truncated frames
// followed by ticks, one-byte requests and noise. Runs several register
// settings, the extremes among them, with random idling on both channels
// and one long receiver stall. Checking is done by ufrc_checker.
// ----------------------------------------------------------------------------
module tb_top;
   import ufrc_pkg::*;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_data  = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_data;
   logic       csr_wr_en = 1'b0;
   logic [1:0] csr_index = CSR_TIMEOUT;
   logic [9:0] csr_wdata = 10'd0;

   int chk_errors;
   int chk_pending;
   int chk_checked;
   int chk_frames;

   // settings currently written, mirrored for stimulus shaping
   logic [9:0] cur_timeout = TIMEOUT_RST;
   logic [7:0] cur_version = VERSION_RST;
   logic [5:0] cur_max_len = MAX_LEN_RST;

   int items_sent     = 0;
   int settings_used  = 1;
   bit stall_request  = 1'b0;
   bit stall_done     = 1'b0;

   uart_frame_receiver_crc16_top dut (.*);

   ufrc_checker chk (
      .*,
      .error_count   (chk_errors),
      .pending_count (chk_pending),
      .checked_count (chk_checked),
      .frame_count   (chk_frames)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #10_000_000;
      $display("tb_top: errors");
      $finish;
   end

   // mostly short gaps, a few long ones
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [15:0] wire_crc(logic [15:0] c, logic [7:0] d);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ d[i];
         c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return c;
   endfunction

   // one request transfer, valid held until accepted
   task automatic send_item(logic cmd, logic [7:0] b);
      int      gap;
      req_type item;
      gap = idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      item.command = cmd;
      item.rx_byte = b;
      req_data  <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_tick();
      send_item(CMD_TICK, 8'($urandom_range(0, 255)));
   endtask

   task automatic send_data(logic [7:0] b, int tick_pct);
      if ($urandom_range(0, 99) < tick_pct) send_tick();
      send_item(CMD_BYTE, b);
   endtask

   // start word, header, payload and crc; cut >= 0 stops after that many
   // bytes past the start word and then lets ticks run
   task automatic send_frame(logic [7:0] ver, logic [15:0] len, bit corrupt,
                             int tick_pct, int cut);
      logic [7:0]  wire_q[$];
      logic [47:0] hdr;
      logic [15:0] crc;
      logic [7:0]  b;
      int          n_pay;
      int          n_ticks;
      wire_q.push_back(CH_B_UP);
      wire_q.push_back(CH_L_UP);
      wire_q.push_back(CH_U_UP);
      wire_q.push_back(CH_P_UP);
      hdr = {ver, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), len};
      crc = CRC_INIT;
      for (int i = 0; i < 6; i++) begin
         b   = hdr[47 - 8 * i -: 8];
         crc = wire_crc(crc, b);
         wire_q.push_back(b);
      end
      n_pay = (len <= MAX_PAYLOAD) ? int'(len) : 0;
      for (int i = 0; i < n_pay; i++) begin
         b   = 8'($urandom_range(0, 255));
         crc = wire_crc(crc, b);
         wire_q.push_back(b);
      end
      if (corrupt) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
      wire_q.push_back(crc[15:8]);
      wire_q.push_back(crc[7:0]);
      for (int i = 0; i < wire_q.size(); i++) begin
         if (cut >= 0 && i == cut + 4) break;
         send_data(wire_q[i], tick_pct);
      end
      if (cut >= 0) begin
         n_ticks = (cur_timeout <= 16) ? int'(cur_timeout) : $urandom_range(1, 3);
         repeat (n_ticks) send_tick();
      end
   endtask

   // wait for every owed result, then for the pipeline to go quiet
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (chk_pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic apply_setting(logic [9:0] t, logic [7:0] v, logic [5:0] m);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_TIMEOUT;
      csr_wdata <= t;
      @(posedge clock);
      csr_index <= CSR_VERSION;
      csr_wdata <= 10'(v);
      @(posedge clock);
      csr_index <= CSR_MAX_LEN;
      csr_wdata <= 10'(m);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cur_timeout = t;
      cur_version = v;
      cur_max_len = m;
      settings_used++;
   endtask

   // extremes and special cases under the reset settings
   task automatic directed_cases();
      send_tick();
      send_item(CMD_BYTE, 8'h00);
      send_item(CMD_BYTE, 8'hFF);
      send_item(CMD_BYTE, CH_QUERY);
      send_item(CMD_BYTE, CH_A_UP);
      send_item(CMD_BYTE, CH_D_UP);
      // start word restarts on a second B
      send_item(CMD_BYTE, CH_B_UP);
      send_item(CMD_BYTE, CH_L_UP);
      send_item(CMD_BYTE, CH_B_UP);
      // empty payload with debug letters
      send_frame(VERSION_RST, 16'd0, 1'b0, 0, -1);
      send_item(CMD_BYTE, CH_D_UP);
      send_frame(8'hFE, 16'd1, 1'b0, 0, -1);
      send_item(CMD_BYTE, CH_D_UP);
      send_frame(VERSION_RST, 16'hFFFF, 1'b0, 0, -1);
      // length check uses the high byte too
      send_frame(VERSION_RST, 16'h0100, 1'b0, 0, -1);
      send_frame(VERSION_RST, 16'd2, 1'b1, 0, -1);
      // debug on with a full payload hits the result cap
      send_item(CMD_BYTE, CH_D_UP);
      send_frame(VERSION_RST, 16'd63, 1'b0, 0, -1);
   endtask

   task automatic random_traffic(int n);
      int          stop;
      int          r;
      int          sub;
      int          lim;
      int          cut;
      int          tick_pct;
      logic [7:0]  ver;
      logic [15:0] len;
      bit          corrupt;
      stop = items_sent + n;
      while (items_sent < stop) begin
         r = $urandom_range(0, 99);
         if (r < 62) begin
            // frames, mostly well-formed with small payloads
            ver     = cur_version;
            corrupt = 1'b0;
            cut     = -1;
            lim     = (cur_max_len < 8) ? int'(cur_max_len) : 8;
            sub     = $urandom_range(0, 99);
            if (sub < 80) len = 16'($urandom_range(0, lim));
            else if (sub < 95) len = 16'($urandom_range(0, cur_max_len));
            else len = 16'(cur_max_len);
            sub = $urandom_range(0, 99);
            if (sub < 8) begin
               ver = cur_version ^ 8'($urandom_range(1, 255));
            end else if (sub < 16) begin
               if (cur_max_len < MAX_PAYLOAD && $urandom_range(0, 1))
                  len = 16'($urandom_range(cur_max_len + 1, MAX_PAYLOAD));
               else
                  len = 16'($urandom_range(64, 65535));
            end else if (sub < 26) begin
               corrupt = 1'b1;
            end else if (sub < 36) begin
               cut = $urandom_range(0, 7 + len);
            end
            tick_pct = (cur_timeout < 8) ? 3 : 10;
            if ($urandom_range(0, 99) < 20) send_item(CMD_BYTE, CH_D_UP);
            send_frame(ver, len, corrupt, tick_pct, cut);
         end else if (r < 76) begin
            case ($urandom_range(0, 2))
               0:       send_item(CMD_BYTE, CH_QUERY);
               1:       send_item(CMD_BYTE, CH_D_UP);
               default: send_item(CMD_BYTE, CH_A_UP);
            endcase
         end else if (r < 90) begin
            repeat ($urandom_range(1, 4)) begin
               if ($urandom_range(0, 1)) send_tick();
               else send_item(CMD_BYTE, 8'($urandom_range(0, 255)));
            end
         end else begin
            // broken start word
            send_item(CMD_BYTE, CH_B_UP);
            if ($urandom_range(0, 1)) send_item(CMD_BYTE, CH_L_UP);
            if ($urandom_range(0, 1)) send_item(CMD_BYTE, CH_U_UP);
            send_item(CMD_BYTE, 8'($urandom_range(0, 255)));
         end
      end
   endtask

   // receiver side: random ready with one long hold-off
   initial begin : rsp_side
      int on_len;
      int off_len;
      @(posedge clock);
      forever begin
         if (stall_request && !stall_done) begin
            stall_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
         end
         off_len = idle_gap();
         if (off_len > 0) begin
            rsp_ready <= 1'b0;
            repeat (off_len) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         on_len = $urandom_range(1, 24);
         repeat (on_len) @(posedge clock);
      end
   end

   // stimulus and verdict
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset settings
      directed_cases();
      stall_request = 1'b1;
      random_traffic(30);
      settle();

      // shortest timeout, version zero, no payload allowed
      apply_setting(10'd1, 8'd0, 6'd0);
      send_item(CMD_BYTE, CH_D_UP);
      send_frame(8'd0, 16'd0, 1'b0, 0, 2);
      send_item(CMD_BYTE, CH_D_UP);
      send_frame(8'd0, 16'd0, 1'b0, 0, 6);
      random_traffic(30);
      settle();

      // longest timeout, top version, full payload
      apply_setting(10'd1023, 8'd255, 6'd63);
      random_traffic(30);
      settle();

      // random middle settings
      apply_setting(10'($urandom_range(2, 12)), 8'($urandom_range(0, 255)),
                    6'($urandom_range(1, 62)));
      random_traffic(30);
      settle();

      // short timeout with payload, payload timeout first
      apply_setting(10'd4, 8'($urandom_range(0, 255)), 6'd63);
      send_item(CMD_BYTE, CH_D_UP);
      send_frame(cur_version, 16'd5, 1'b0, 0, 8);
      random_traffic(30);
      settle();

      $display("tb_top: %0d items over %0d register settings, %0d results compared, %0d frames",
               items_sent, settings_used, chk_checked, chk_frames);
      $display("tb_top: covered requests, start word restart, bad version/length/crc,");
      $display("tb_top: segment timeouts, debug letters, result cap and a long receiver stall");
      if (chk_errors == 0 && chk_pending == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/ufrc_pkg.sv
rtl/ufrc_front.sv
rtl/ufrc_queue.sv
rtl/ufrc_back.sv
rtl/uart_frame_receiver_crc16_top.sv
dv/ufrc_checker.sv
dv/tb_top.sv
